// File: hdl/zyzp_pkg.sv
// Package: constants, types and helpers for the ZYZ pose to homogeneous matrix block.
package zyzp_pkg;

    localparam int ANGLE_WIDTH    = 26;
    localparam int POS_WIDTH      = 32;
    localparam int TRIG_FRAC_BITS = 16;
    localparam int ROT_WIDTH      = TRIG_FRAC_BITS + 2;
    localparam int WQ             = 30;              // internal trig/matrix fraction bits
    localparam int MAG_W          = WQ + 1;          // magnitude up to 1.0 in Q30
    localparam int SUM_W          = MAG_W + 2;       // signed sum of two Q30 terms

    // angle reduction, in 1/65536 degree
    localparam int FULL_TURN      = 23592960;
    localparam int QUARTER_TURN   = 5898240;
    localparam int EIGHTH_TURN    = 2949120;
    localparam int TURN_W         = 25;              // [0, 360) degrees
    localparam int QTR_W          = 23;              // [0, 90) degrees
    localparam int OCT_W          = 22;              // [0, 45] degrees

    // round(pi/180 * 2^46), split for two narrower multipliers
    localparam logic [40:0] DEG_TO_RAD_K = 41'd1228166276394;
    localparam logic [19:0] K_LO         = DEG_TO_RAD_K[19:0];
    localparam logic [20:0] K_HI         = DEG_TO_RAD_K[40:20];

    localparam int X_W   = 30;
    localparam int T_W   = 31;
    localparam int REM_W = 8;
    localparam logic [T_W-1:0] T_ONE = T_W'(64'd1 << WQ);

    // series steps: Horner divisors
    localparam int N_STEPS    = 5;
    localparam int STEP_DEPTH = 4;
    localparam int COS_K [N_STEPS]   = '{90, 56, 30, 12, 2};
    localparam int SIN_K [N_STEPS-1] = '{72, 42, 20, 6};

    localparam int TRIG_LAT = 6 + N_STEPS * STEP_DEPTH + 2;
    localparam int MAT_LAT  = 7;
    localparam int PIPE_LAT = TRIG_LAT + MAT_LAT;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sm_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos_z;
        logic signed [POS_WIDTH-1:0] pos_y;
        logic signed [POS_WIDTH-1:0] pos_x;
    } pos_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] angle_last_z;
        logic signed [ANGLE_WIDTH-1:0] angle_middle_y;
        logic signed [ANGLE_WIDTH-1:0] angle_first_z;
        pos_t                          pos;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] t2;
        logic signed [ROT_WIDTH-1:0] r22;
        logic signed [ROT_WIDTH-1:0] r21;
        logic signed [ROT_WIDTH-1:0] r20;
        logic signed [POS_WIDTH-1:0] t1;
        logic signed [ROT_WIDTH-1:0] r12;
        logic signed [ROT_WIDTH-1:0] r11;
        logic signed [ROT_WIDTH-1:0] r10;
        logic signed [POS_WIDTH-1:0] t0;
        logic signed [ROT_WIDTH-1:0] r02;
        logic signed [ROT_WIDTH-1:0] r01;
        logic signed [ROT_WIDTH-1:0] r00;
    } out_item_t;

    localparam int IN_W       = $bits(in_item_t);
    localparam int OUT_W      = $bits(out_item_t);
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    function automatic sm_t sm_flip(input sm_t a);
        sm_t r;
        r     = a;
        r.neg = ~a.neg;
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sm_to_s(input sm_t a);
        logic signed [SUM_W-1:0] m;
        m = $signed({2'b00, a.mag});
        return a.neg ? -m : m;
    endfunction

    // Q30 magnitude product rounded half up (half away from zero on magnitudes)
    function automatic logic [MAG_W-1:0] rnd_q(input logic [2*MAG_W-1:0] p);
        logic [2*MAG_W-1:0] s;
        s = p + ((2*MAG_W)'(1) << (WQ - 1));
        return s[WQ +: MAG_W];
    endfunction

endpackage

// File: hdl/zyzp_trig.sv
// Pipelined sine/cosine of an angle in 1/65536 degree, sign-magnitude Q30 results.
module zyzp_trig import zyzp_pkg::*; (
    input  logic                          aclk,
    input  logic                          ce,
    input  logic signed [ANGLE_WIDTH-1:0] angle,
    output sm_t                           sin_o,
    output sm_t                           cos_o
);

    typedef struct packed {
        logic [X_W-1:0] x2;
        logic [X_W-1:0] x;
        logic [1:0]     quad;
        logic           swap;
    } trig_sd_t;

    localparam int SD_N = N_STEPS * STEP_DEPTH;

    // stage 1: reduce into [0, 360)
    logic signed [27:0] a_ext, a_p1, a_p2, a_m1;
    logic [TURN_W-1:0]  m_next, m_reg;

    assign a_ext = 28'(angle);
    assign a_p1  = a_ext + 28'(FULL_TURN);
    assign a_p2  = a_ext + 28'(2 * FULL_TURN);
    assign a_m1  = a_ext - 28'(FULL_TURN);

    always_comb begin
        priority if (a_ext[27] && a_p1[27]) begin
            m_next = a_p2[TURN_W-1:0];
        end else if (a_ext[27]) begin
            m_next = a_p1[TURN_W-1:0];
        end else if (!a_m1[27]) begin
            m_next = a_m1[TURN_W-1:0];
        end else begin
            m_next = a_ext[TURN_W-1:0];
        end
    end

    // stage 2: quadrant
    logic [QTR_W-1:0] r_next, r_reg;
    logic [1:0]       quad_next, quad2_reg;

    always_comb begin
        priority if (m_reg >= TURN_W'(3 * QUARTER_TURN)) begin
            quad_next = 2'd3;
            r_next    = QTR_W'(m_reg - TURN_W'(3 * QUARTER_TURN));
        end else if (m_reg >= TURN_W'(2 * QUARTER_TURN)) begin
            quad_next = 2'd2;
            r_next    = QTR_W'(m_reg - TURN_W'(2 * QUARTER_TURN));
        end else if (m_reg >= TURN_W'(QUARTER_TURN)) begin
            quad_next = 2'd1;
            r_next    = QTR_W'(m_reg - TURN_W'(QUARTER_TURN));
        end else begin
            quad_next = 2'd0;
            r_next    = m_reg[QTR_W-1:0];
        end
    end

    // stage 3: fold to [0, 45]
    logic [OCT_W-1:0] rf_next, rf_reg;
    logic             swap_next, swap3_reg, swap4_reg, swap5_reg;
    logic [1:0]       quad3_reg, quad4_reg, quad5_reg;

    always_comb begin
        if (r_reg > QTR_W'(EIGHTH_TURN)) begin
            rf_next   = OCT_W'(QTR_W'(QUARTER_TURN) - r_reg);
            swap_next = 1'b1;
        end else begin
            rf_next   = r_reg[OCT_W-1:0];
            swap_next = 1'b0;
        end
    end

    // stages 4/5: degrees to radians, two partial products then the sum
    logic [41:0]    plo_next, plo_reg;
    logic [42:0]    phi_next, phi_reg;
    logic [62:0]    xs;
    logic [X_W-1:0] x_reg;
    logic [59:0]    xx;

    assign plo_next = 42'(rf_reg) * 42'(K_LO);
    assign phi_next = 43'(rf_reg) * 43'(K_HI);
    assign xs       = {phi_reg, 20'd0} + 63'(plo_reg) + (63'(1) << 31);
    assign xx       = 60'(x_reg) * 60'(x_reg);

    trig_sd_t sd_reg [SD_N+1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_reg     <= m_next;
            r_reg     <= r_next;
            quad2_reg <= quad_next;
            rf_reg    <= rf_next;
            swap3_reg <= swap_next;
            quad3_reg <= quad2_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            swap4_reg <= swap3_reg;
            quad4_reg <= quad3_reg;
            x_reg     <= xs[61:32];
            swap5_reg <= swap4_reg;
            quad5_reg <= quad4_reg;
            sd_reg[0] <= '{x2: xx[59:30], x: x_reg, quad: quad5_reg, swap: swap5_reg};
            for (int k = 1; k <= SD_N; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // Horner steps: t = 1 - floor(m(x2,t) / k); each step is four stages
    logic [T_W-1:0] tc_reg [N_STEPS];
    logic [T_W-1:0] ts_reg [1:N_STEPS-1];

    for (genvar j = 0; j < N_STEPS; j++) begin : g_cos
        localparam logic [30:0] MC = 31'((64'd1 << 31) / COS_K[j]);
        logic [T_W-1:0]   tin;
        logic [60:0]      pa, vm;
        logic [36:0]      qk;
        logic [X_W-1:0]   v_reg, vb_reg, q_reg, q2_reg;
        logic [REM_W-1:0] rem_reg;

        if (j == 0) begin : g_first
            assign tin = T_ONE;
        end else begin : g_chain
            assign tin = tc_reg[j-1];
        end

        assign pa = 61'(sd_reg[STEP_DEPTH*j].x2) * 61'(tin);
        assign vm = 61'(v_reg) * 61'(MC);
        assign qk = 37'(q_reg) * 37'(COS_K[j]);

        always_ff @(posedge aclk) begin
            if (ce) begin
                v_reg     <= pa[59:30];
                q_reg     <= vm[60:31];
                vb_reg    <= v_reg;
                rem_reg   <= REM_W'(vb_reg - qk[X_W-1:0]);
                q2_reg    <= q_reg;
                tc_reg[j] <= T_ONE - T_W'(q2_reg) - T_W'(rem_reg >= REM_W'(COS_K[j]));
            end
        end
    end

    for (genvar j = 1; j < N_STEPS; j++) begin : g_sin
        localparam logic [30:0] MS = 31'((64'd1 << 31) / SIN_K[j-1]);
        logic [T_W-1:0]   tin;
        logic [60:0]      pa, vm;
        logic [36:0]      qk;
        logic [X_W-1:0]   v_reg, vb_reg, q_reg, q2_reg;
        logic [REM_W-1:0] rem_reg;

        if (j == 1) begin : g_first
            assign tin = T_ONE;
        end else begin : g_chain
            assign tin = ts_reg[j-1];
        end

        assign pa = 61'(sd_reg[STEP_DEPTH*j].x2) * 61'(tin);
        assign vm = 61'(v_reg) * 61'(MS);
        assign qk = 37'(q_reg) * 37'(SIN_K[j-1]);

        always_ff @(posedge aclk) begin
            if (ce) begin
                v_reg     <= pa[59:30];
                q_reg     <= vm[60:31];
                vb_reg    <= v_reg;
                rem_reg   <= REM_W'(vb_reg - qk[X_W-1:0]);
                q2_reg    <= q_reg;
                ts_reg[j] <= T_ONE - T_W'(q2_reg) - T_W'(rem_reg >= REM_W'(SIN_K[j-2+1]));
            end
        end
    end

    // final: sin = x * t, then octant/quadrant mapping
    logic [60:0]      sp;
    logic [MAG_W-1:0] sv_reg, cv_reg, s0, c0;
    logic [1:0]       quadf_reg;
    logic             swapf_reg;
    sm_t              sin_next, cos_next, sin_reg, cos_reg;

    assign sp = 61'(sd_reg[SD_N].x) * 61'(ts_reg[N_STEPS-1]);
    assign s0 = swapf_reg ? cv_reg : sv_reg;
    assign c0 = swapf_reg ? sv_reg : cv_reg;

    always_comb begin
        unique case (quadf_reg)
            2'd0: begin
                sin_next = '{neg: 1'b0, mag: s0};
                cos_next = '{neg: 1'b0, mag: c0};
            end
            2'd1: begin
                sin_next = '{neg: 1'b0, mag: c0};
                cos_next = '{neg: 1'b1, mag: s0};
            end
            2'd2: begin
                sin_next = '{neg: 1'b1, mag: s0};
                cos_next = '{neg: 1'b1, mag: c0};
            end
            default: begin
                sin_next = '{neg: 1'b1, mag: c0};
                cos_next = '{neg: 1'b0, mag: s0};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sv_reg    <= sp[60:30];
            cv_reg    <= tc_reg[N_STEPS-1];
            quadf_reg <= sd_reg[SD_N].quad;
            swapf_reg <= sd_reg[SD_N].swap;
            sin_reg   <= sin_next;
            cos_reg   <= cos_next;
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

// File: hdl/zyz_pose_to_homogeneous_matrix.sv
// Top level: ZYZ Euler pose to the top three rows of a homogeneous transform.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: pos_x pos_y pos_z, ZYZ angles
//  m_      | out | m_tvalid/m_tready  | m_tdata: rotation rows and translation
//
//  One request per cycle sustained while the skid slot is empty; a request runs
//  from acceptance through a sine/cosine pipe and matrix stages M1-M7 to the
//  output register. The trig depth is set by the Horner series: five steps of
//  multiply, reciprocal multiply and remainder correction, four stages each.
//  aresetn (synchronous) clears the valid bits, output and skid flags only.
//  A stalled output parks one further result in the skid register; while it
//  is full the whole pipe holds and s_tready is low. Nothing is lost or doubled.
module zyz_pose_to_homogeneous_matrix import zyzp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pos_x, pos_y, pos_z, angle_first_z, angle_middle_y, angle_last_z, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // r00 r01 r02 t0 r10 r11 r12 t1 r20 r21 r22 t2, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // first-level product terms
    localparam int CACB = 0;
    localparam int SACB = 1;
    localparam int SASC = 2;
    localparam int SACC = 3;
    localparam int CASB = 4;
    localparam int CASC = 5;
    localparam int CACC = 6;
    localparam int SASB = 7;
    localparam int SBCC = 8;
    localparam int SBSC = 9;
    localparam int N_L1 = 10;
    localparam int N_L2 = 4;
    localparam int N_ROT = 9;

    localparam int SH     = WQ - TRIG_FRAC_BITS;
    localparam int RND_W  = SUM_W - SH;
    localparam logic [SUM_W-2:0] RND_HALF = (SH == 0) ? '0 : ((SUM_W-1)'(1) << (SH - 1));
    localparam logic [RND_W-1:0] ROT_LIM  = RND_W'(1) << TRIG_FRAC_BITS;

    in_item_t in_item;
    logic     ce;
    logic     m_tvalid_reg, skid_vld_reg;

    assign in_item  = s_tdata[IN_W-1:0];
    assign ce       = ~skid_vld_reg;   // pipe moves whenever the skid slot is free
    assign s_tready = ce;

    // valid bits and the translation ride alongside the arithmetic
    logic vld_reg [PIPE_LAT];
    pos_t pos_reg [PIPE_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < PIPE_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pos_reg[0] <= in_item.pos;
            for (int k = 1; k < PIPE_LAT; k++) begin
                pos_reg[k] <= pos_reg[k-1];
            end
        end
    end

    // three sine/cosine pipes
    sm_t sa, ca, sb, cb, sc, cc;

    zyzp_trig u_trig_a (
        .aclk  (aclk),
        .ce    (ce),
        .angle (in_item.angle_first_z),
        .sin_o (sa),
        .cos_o (ca)
    );

    zyzp_trig u_trig_b (
        .aclk  (aclk),
        .ce    (ce),
        .angle (in_item.angle_middle_y),
        .sin_o (sb),
        .cos_o (cb)
    );

    zyzp_trig u_trig_c (
        .aclk  (aclk),
        .ce    (ce),
        .angle (in_item.angle_last_z),
        .sin_o (sc),
        .cos_o (cc)
    );

    // first-level operands
    sm_t l1a [N_L1];
    sm_t l1b [N_L1];

    assign l1a[CACB] = ca;  assign l1b[CACB] = cb;
    assign l1a[SACB] = sa;  assign l1b[SACB] = cb;
    assign l1a[SASC] = sa;  assign l1b[SASC] = sc;
    assign l1a[SACC] = sa;  assign l1b[SACC] = cc;
    assign l1a[CASB] = ca;  assign l1b[CASB] = sb;
    assign l1a[CASC] = ca;  assign l1b[CASC] = sc;
    assign l1a[CACC] = ca;  assign l1b[CACC] = cc;
    assign l1a[SASB] = sa;  assign l1b[SASB] = sb;
    assign l1a[SBCC] = sb;  assign l1b[SBCC] = cc;
    assign l1a[SBSC] = sb;  assign l1b[SBSC] = sc;

    // M1/M2: first-level products, then rounding
    logic [2*MAG_W-1:0] p1_reg [N_L1];
    logic               n1_reg [N_L1];
    sm_t                l1_reg [N_L1];
    sm_t                l1d3_reg [N_L1];
    sm_t                l1d4_reg [N_L1];
    sm_t                sc_d1_reg, sc_d2_reg, cc_d1_reg, cc_d2_reg;
    sm_t                cb_d_reg [4];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < N_L1; i++) begin
                p1_reg[i]   <= (2*MAG_W)'(l1a[i].mag) * (2*MAG_W)'(l1b[i].mag);
                n1_reg[i]   <= l1a[i].neg ^ l1b[i].neg;
                l1_reg[i]   <= '{neg: n1_reg[i], mag: rnd_q(p1_reg[i])};
                l1d3_reg[i] <= l1_reg[i];
                l1d4_reg[i] <= l1d3_reg[i];
            end
            sc_d1_reg   <= sc;
            sc_d2_reg   <= sc_d1_reg;
            cc_d1_reg   <= cc;
            cc_d2_reg   <= cc_d1_reg;
            cb_d_reg[0] <= cb;
            for (int k = 1; k < 4; k++) begin
                cb_d_reg[k] <= cb_d_reg[k-1];
            end
        end
    end

    // M3/M4: second level: cacb*cc, cacb*sc, sacb*cc, sacb*sc
    sm_t                l2a [N_L2];
    sm_t                l2b [N_L2];
    logic [2*MAG_W-1:0] p2_reg [N_L2];
    logic               n2_reg [N_L2];
    sm_t                l2_reg [N_L2];

    assign l2a[0] = l1_reg[CACB];  assign l2b[0] = cc_d2_reg;
    assign l2a[1] = l1_reg[CACB];  assign l2b[1] = sc_d2_reg;
    assign l2a[2] = l1_reg[SACB];  assign l2b[2] = cc_d2_reg;
    assign l2a[3] = l1_reg[SACB];  assign l2b[3] = sc_d2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < N_L2; i++) begin
                p2_reg[i] <= (2*MAG_W)'(l2a[i].mag) * (2*MAG_W)'(l2b[i].mag);
                n2_reg[i] <= l2a[i].neg ^ l2b[i].neg;
                l2_reg[i] <= '{neg: n2_reg[i], mag: rnd_q(p2_reg[i])};
            end
        end
    end

    // M5: entry sums in Q30
    logic signed [SUM_W-1:0] e_next [N_ROT];
    logic signed [SUM_W-1:0] e_reg  [N_ROT];

    always_comb begin
        e_next[0] = sm_to_s(l2_reg[0]) + sm_to_s(sm_flip(l1d4_reg[SASC]));
        e_next[1] = sm_to_s(sm_flip(l2_reg[1])) + sm_to_s(sm_flip(l1d4_reg[SACC]));
        e_next[2] = sm_to_s(l1d4_reg[CASB]);
        e_next[3] = sm_to_s(l2_reg[2]) + sm_to_s(l1d4_reg[CASC]);
        e_next[4] = sm_to_s(sm_flip(l2_reg[3])) + sm_to_s(l1d4_reg[CACC]);
        e_next[5] = sm_to_s(l1d4_reg[SASB]);
        e_next[6] = sm_to_s(sm_flip(l1d4_reg[SBCC]));
        e_next[7] = sm_to_s(l1d4_reg[SBSC]);
        e_next[8] = sm_to_s(cb_d_reg[3]);
    end

    // M6: magnitude and rounding to the output fraction; M7: clamp and sign
    logic [SUM_W-2:0]            emag [N_ROT];
    logic [SUM_W-2:0]            esum [N_ROT];
    logic [RND_W-1:0]            rnd_reg [N_ROT];
    logic                        rneg_reg [N_ROT];
    logic [RND_W-1:0]            clamped [N_ROT];
    logic signed [ROT_WIDTH-1:0] rot_next [N_ROT];
    logic signed [ROT_WIDTH-1:0] rot_reg  [N_ROT];

    always_comb begin
        for (int i = 0; i < N_ROT; i++) begin
            emag[i]     = e_reg[i][SUM_W-1] ? (SUM_W-1)'(-e_reg[i]) : (SUM_W-1)'(e_reg[i]);
            esum[i]     = emag[i] + RND_HALF;
            clamped[i]  = (rnd_reg[i] > ROT_LIM) ? ROT_LIM : rnd_reg[i];
            rot_next[i] = rneg_reg[i] ? -ROT_WIDTH'(clamped[i]) : ROT_WIDTH'(clamped[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < N_ROT; i++) begin
                e_reg[i]    <= e_next[i];
                rnd_reg[i]  <= RND_W'(esum[i] >> SH);
                rneg_reg[i] <= e_reg[i][SUM_W-1];
                rot_reg[i]  <= rot_next[i];
            end
        end
    end

    // result assembly
    out_item_t pipe_item;

    always_comb begin
        pipe_item.r00 = rot_reg[0];
        pipe_item.r01 = rot_reg[1];
        pipe_item.r02 = rot_reg[2];
        pipe_item.t0  = pos_reg[PIPE_LAT-1].pos_x;
        pipe_item.r10 = rot_reg[3];
        pipe_item.r11 = rot_reg[4];
        pipe_item.r12 = rot_reg[5];
        pipe_item.t1  = pos_reg[PIPE_LAT-1].pos_y;
        pipe_item.r20 = rot_reg[6];
        pipe_item.r21 = rot_reg[7];
        pipe_item.r22 = rot_reg[8];
        pipe_item.t2  = pos_reg[PIPE_LAT-1].pos_z;
    end

    // output register with a one-deep skid slot
    out_item_t out_reg, skid_reg;
    logic      out_load;

    assign out_load = ~m_tvalid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_load) begin
            if (skid_vld_reg) begin
                m_tvalid_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= vld_reg[PIPE_LAT-1];
            end
        end else if (vld_reg[PIPE_LAT-1] && ce) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= skid_vld_reg ? skid_reg : pipe_item;
        end else if (ce) begin
            skid_reg <= pipe_item;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_W)'(0), out_reg};

    // checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_tvalid_reg)
        else $error("skid slot full while output register empty");

    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid slot filled without an output stall");

    a_pipe_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg[PIPE_LAT-1]))
        else $error("pipe moved while stalled");

    a_r22_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ($signed(out_reg.r22) <= $signed({2'b00, ROT_LIM[TRIG_FRAC_BITS-1+1:0]})
                          && $signed(out_reg.r22) >= -$signed({2'b00, ROT_LIM[TRIG_FRAC_BITS:0]})))
        else $error("rotation entry beyond unit magnitude");

endmodule
